// ===== sv/assert_macros.svh =====
// Assertion helpers for the module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCDDA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcdda: same-cycle check failed");

// The consequent must hold later than the antecedent.
`define PCDDA_ASSERT_LATER(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("pcdda: two-cycle check failed");

`endif

// ===== sv/pcdda_pkg.sv =====
package pcdda_pkg;

   // Operation codes carried on the request channel.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Control and status register map.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DELAY       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYPASS          = 2'd2;

   // Register reset values.
   localparam logic [8:0] CHANNELS_IN_USE_RESET = 9'd256;
   localparam logic [7:0] MAX_DELAY_RESET       = 8'd0;
   localparam logic       BYPASS_RESET          = 1'b1;

   localparam int WORD_W = 32;

   // Response queue sizing.
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = 2;
   localparam int RSP_CNT_W      = 3;

   // Control carried from the front stage into the history stage.
   typedef struct packed {
      logic valid;
      logic last;
   } front_ctl_type;

   // Control carried from the history read into the response queue.
   typedef struct packed {
      logic valid;
      logic zero_lag;
      logic last;
   } hist_ctl_type;

   // One response transaction.
   typedef struct packed {
      logic [WORD_W-1:0] aligned_word;
      logic [7:0]        out_channel;
      logic              spectrum_end;
   } rsp_item_type;

endpackage

// ===== sv/per_channel_dispersion_delay_aligner_unit.sv =====
// Dedispersion channel aligner for one dispersion measure. Samples come in time
// order, channel by channel, and each one returns the same channel's sample from
// (max_delay - delay) spectra earlier, so every channel lines up with the most
// delayed one; bypass passes samples straight through. Load transactions write the
// per-channel delay table and return nothing. One transaction is taken every clock
// while req_stall is low: each sample costs one write and one read of the history
// memory, whose single write port sets that figure. A result passes the front and
// history stage registers into a four-entry response queue, which drives the rsp_
// ports and keeps the request side moving while a result waits.
// After reset the block clears its history memory, one entry a cycle, over all
// HISTORY_DEPTH * 2**CH_W entries (65536 at the default sizes), and holds
// req_stall high meanwhile; configuration writes are taken at any time
// and should be made while idle.
`include "assert_macros.svh"

module per_channel_dispersion_delay_aligner_unit import pcdda_pkg::*; #(
   parameter int MAX_CHANNELS  = 256,
   parameter int HISTORY_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [7:0]             req_load_channel,
   input  logic [7:0]             req_load_delay,
   input  logic [WORD_W-1:0]      req_sample_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_W-1:0]      rsp_aligned_word,
   output logic [7:0]             rsp_out_channel,
   output logic                   rsp_spectrum_end,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int T_W  = $clog2(HISTORY_DEPTH);

   logic [8:0] channels_in_use_ff, channels_in_use_in;
   logic [7:0] max_delay_ff, max_delay_in;
   logic       bypass_ff, bypass_in;

   logic                 req_accept;
   logic                 sample_accept;
   logic                 clr_active;
   logic [CH_W-1:0]      clr_channel;
   front_ctl_type        s1_ctl;
   logic [CH_W-1:0]      s1_channel;
   logic [T_W-1:0]       s1_time;
   logic [WORD_W-1:0]    s1_word;
   logic [7:0]           s1_delay;
   logic                 push_valid;
   rsp_item_type         push_item;
   rsp_item_type         rsp_item;
   logic [RSP_CNT_W-1:0] fifo_count;
   logic [RSP_CNT_W-1:0] pending;

   // Configuration registers.
   always_comb begin
      channels_in_use_in = channels_in_use_ff;
      max_delay_in       = max_delay_ff;
      bypass_in          = bypass_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CHANNELS_IN_USE: channels_in_use_in = csr_write_data[8:0];
            CSR_MAX_DELAY:       max_delay_in       = csr_write_data[7:0];
            CSR_BYPASS:          bypass_in          = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_in_use_ff <= CHANNELS_IN_USE_RESET;
         max_delay_ff       <= MAX_DELAY_RESET;
         bypass_ff          <= BYPASS_RESET;
      end else begin
         channels_in_use_ff <= channels_in_use_in;
         max_delay_ff       <= max_delay_in;
         bypass_ff          <= bypass_in;
      end
   end

   // Credit check: results in flight plus queued results never exceed the queue depth.
   always_comb begin
      pending       = fifo_count + RSP_CNT_W'(s1_ctl.valid) + RSP_CNT_W'(push_valid);
      req_stall     = clr_active || (pending >= RSP_CNT_W'(RSP_FIFO_DEPTH));
      req_accept    = req_valid && !req_stall;
      sample_accept = req_accept && (req_operation == OP_SAMPLE);
   end

   pcdda_front #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .operation       (req_operation),
      .load_channel    (req_load_channel),
      .load_delay      (req_load_delay),
      .sample_word     (req_sample_word),
      .channels_in_use (channels_in_use_ff),
      .clr_active      (clr_active),
      .clr_channel     (clr_channel),
      .s1_ctl          (s1_ctl),
      .s1_channel      (s1_channel),
      .s1_time         (s1_time),
      .s1_word         (s1_word),
      .s1_delay        (s1_delay)
   );

   pcdda_history #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock       (clock),
      .reset       (reset),
      .s1_ctl      (s1_ctl),
      .s1_channel  (s1_channel),
      .s1_time     (s1_time),
      .s1_word     (s1_word),
      .s1_delay    (s1_delay),
      .max_delay   (max_delay_ff),
      .bypass      (bypass_ff),
      .clr_active  (clr_active),
      .clr_channel (clr_channel),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   pcdda_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .count      (fifo_count)
   );

   assign rsp_aligned_word = rsp_item.aligned_word;
   assign rsp_out_channel  = rsp_item.out_channel;
   assign rsp_spectrum_end = rsp_item.spectrum_end;

   // Checks on the clearing sweep, the credit scheme and the pipeline length.
   `PCDDA_ASSERT_IMPLY(a_no_accept_while_clearing, clock, reset, req_accept, !clr_active)
   `PCDDA_ASSERT_IMPLY(a_credit_bound, clock, reset, 1'b1, pending <= RSP_CNT_W'(RSP_FIFO_DEPTH))
   `PCDDA_ASSERT_LATER(a_sample_reaches_queue, clock, reset, sample_accept, push_valid)

endmodule

// ===== sv/pcdda_front.sv =====
module pcdda_front import pcdda_pkg::*; #(
   parameter int MAX_CHANNELS  = 256,
   parameter int HISTORY_DEPTH = 256,
   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int T_W   = $clog2(HISTORY_DEPTH),
   localparam int CNT_W = ((CH_W + 1) > 9) ? (CH_W + 1) : 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                operation,
   input  logic [7:0]          load_channel,
   input  logic [7:0]          load_delay,
   input  logic [WORD_W-1:0]   sample_word,
   input  logic [8:0]          channels_in_use,
   input  logic                clr_active,
   input  logic [CH_W-1:0]     clr_channel,
   output front_ctl_type       s1_ctl,
   output logic [CH_W-1:0]     s1_channel,
   output logic [T_W-1:0]      s1_time,
   output logic [WORD_W-1:0]   s1_word,
   output logic [7:0]          s1_delay
);

   logic [7:0] delay_mem [MAX_CHANNELS];

   logic [CH_W-1:0]   channel_index_ff, channel_index_in;
   logic [T_W-1:0]    time_index_ff, time_index_in;
   front_ctl_type     s1_ctl_ff, s1_ctl_in;
   logic [CH_W-1:0]   s1_channel_ff;
   logic [T_W-1:0]    s1_time_ff;
   logic [WORD_W-1:0] s1_word_ff;
   logic [7:0]        s1_delay_ff;

   logic [CNT_W-1:0] count_raw, count_active, channel_next, load_index, clr_index;
   logic             is_sample, is_load, load_ok, clr_ok, last;

   // Effective channel count and end-of-spectrum detection.
   always_comb begin
      count_raw = CNT_W'(channels_in_use);
      if (count_raw == '0) begin
         count_active = CNT_W'(1);
      end else if (count_raw > CNT_W'(MAX_CHANNELS)) begin
         count_active = CNT_W'(MAX_CHANNELS);
      end else begin
         count_active = count_raw;
      end
      channel_next = CNT_W'(channel_index_ff) + CNT_W'(1);
      last         = (channel_next >= count_active);
      is_sample    = accept && (operation == OP_SAMPLE);
      is_load      = accept && (operation == OP_LOAD);
      load_index   = CNT_W'(load_channel);
      load_ok      = is_load && (load_index < CNT_W'(MAX_CHANNELS));
      clr_index    = CNT_W'(clr_channel);
      clr_ok       = clr_active && (clr_index < CNT_W'(MAX_CHANNELS));
   end

   // Channel and time counters advance on every sample transaction.
   always_comb begin
      channel_index_in = channel_index_ff;
      time_index_in    = time_index_ff;
      if (is_sample) begin
         if (last) begin
            channel_index_in = '0;
            if (time_index_ff == T_W'(HISTORY_DEPTH - 1)) begin
               time_index_in = '0;
            end else begin
               time_index_in = time_index_ff + T_W'(1);
            end
         end else begin
            channel_index_in = channel_next[CH_W-1:0];
         end
      end
      s1_ctl_in.valid = is_sample;
      s1_ctl_in.last  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_index_ff <= '0;
         time_index_ff    <= '0;
         s1_ctl_ff        <= '0;
      end else begin
         channel_index_ff <= channel_index_in;
         time_index_ff    <= time_index_in;
         s1_ctl_ff        <= s1_ctl_in;
      end
   end

   // Sample payload for the history stage.
   always_ff @(posedge clock) begin
      if (is_sample) begin
         s1_channel_ff <= channel_index_ff;
         s1_time_ff    <= time_index_ff;
         s1_word_ff    <= sample_word;
      end
   end

   // Delay table: cleared by the sweep after reset, written by load transactions,
   // read for the channel currently being accepted.
   always_ff @(posedge clock) begin
      if (clr_ok) begin
         delay_mem[clr_channel] <= '0;
      end else if (load_ok) begin
         delay_mem[load_index[CH_W-1:0]] <= load_delay;
      end
      s1_delay_ff <= delay_mem[channel_index_ff];
   end

   assign s1_ctl     = s1_ctl_ff;
   assign s1_channel = s1_channel_ff;
   assign s1_time    = s1_time_ff;
   assign s1_word    = s1_word_ff;
   assign s1_delay   = s1_delay_ff;

endmodule

// ===== sv/pcdda_history.sv =====
module pcdda_history import pcdda_pkg::*; #(
   parameter int MAX_CHANNELS  = 256,
   parameter int HISTORY_DEPTH = 256,
   localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int T_W          = $clog2(HISTORY_DEPTH),
   localparam int LAG_W        = (T_W > 8) ? T_W : 8,
   localparam int AW           = T_W + CH_W,
   localparam int HIST_ENTRIES = HISTORY_DEPTH * (1 << CH_W)
) (
   input  logic              clock,
   input  logic              reset,
   input  front_ctl_type     s1_ctl,
   input  logic [CH_W-1:0]   s1_channel,
   input  logic [T_W-1:0]    s1_time,
   input  logic [WORD_W-1:0] s1_word,
   input  logic [7:0]        s1_delay,
   input  logic [7:0]        max_delay,
   input  logic              bypass,
   output logic              clr_active,
   output logic [CH_W-1:0]   clr_channel,
   output logic              push_valid,
   output rsp_item_type      push_item
);

   logic [WORD_W-1:0] hist_mem [HIST_ENTRIES];

   logic              clr_active_ff, clr_active_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   hist_ctl_type      s2_ctl_ff, s2_ctl_in;
   logic [WORD_W-1:0] s2_word_ff;
   logic [7:0]        s2_channel_ff;
   logic [WORD_W-1:0] hist_rd_ff;

   logic [7:0]        delay_sat, lag_raw;
   logic [LAG_W-1:0]  lag_ext, lag_sat, time_ext, slot_ext;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic              wr_en;

   // Clearing sweep over every history entry after reset, one entry a cycle.
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(HIST_ENTRIES - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
      end
   end

   // Lag and read slot for this channel; a delay above max_delay counts as max_delay.
   always_comb begin
      delay_sat = (s1_delay > max_delay) ? max_delay : s1_delay;
      lag_raw   = max_delay - delay_sat;
      lag_ext   = LAG_W'(lag_raw);
      lag_sat   = (lag_ext > LAG_W'(HISTORY_DEPTH - 1)) ? LAG_W'(HISTORY_DEPTH - 1) : lag_ext;
      time_ext  = LAG_W'(s1_time);
      if (time_ext >= lag_sat) begin
         slot_ext = time_ext - lag_sat;
      end else begin
         slot_ext = time_ext + LAG_W'(HISTORY_DEPTH) - lag_sat;
      end
      rd_addr = {slot_ext[T_W-1:0], s1_channel};
      wr_en   = clr_active_ff || s1_ctl.valid;
      wr_addr = clr_active_ff ? clr_cnt_ff : {s1_time, s1_channel};
      s2_ctl_in.valid    = s1_ctl.valid;
      s2_ctl_in.zero_lag = (lag_sat == '0);
      s2_ctl_in.last     = s1_ctl.last;
   end

   // History memory: one write and one registered read per cycle. A zero lag reads
   // the entry being written in the same cycle, so that case takes the new word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= clr_active_ff ? '0 : s1_word;
      end
      hist_rd_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_word_ff    <= s1_word;
      s2_channel_ff <= 8'(s1_channel);
   end

   // Result selection.
   always_comb begin
      push_item.aligned_word = (bypass || s2_ctl_ff.zero_lag) ? s2_word_ff : hist_rd_ff;
      push_item.out_channel  = s2_channel_ff;
      push_item.spectrum_end = s2_ctl_ff.last;
   end

   assign push_valid  = s2_ctl_ff.valid;
   assign clr_active  = clr_active_ff;
   assign clr_channel = clr_cnt_ff[CH_W-1:0];

endmodule

// ===== sv/pcdda_rsp_fifo.sv =====
module pcdda_rsp_fifo import pcdda_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  rsp_item_type         push_item,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output rsp_item_type         rsp_item,
   output logic [RSP_CNT_W-1:0] count
);

   rsp_item_type         entry_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;

   // Pointer and occupancy update; the credit check upstream keeps it from overflowing.
   always_comb begin
      pop       = (count_ff != '0) && !rsp_stall;
      wr_ptr_in = push_valid ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push_valid) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
